[rtl/assert_macros.svh]
// Assertion macros shared by the memory test pattern checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
	else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_CLK_ALWAYS(label, clk, prop)
`endif
`endif

[rtl/mtpc_pkg.sv]
// Types, codes and helpers of the memory test pattern checker.
package mtpc_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_GEN    = 2'd1,
		CMD_CHECK  = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_ADDR  = 2'd0,
		MODE_WALK  = 2'd1,
		MODE_FIXED = 2'd2,
		MODE_INDEX = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CFG_TEST_MODE     = 2'd0,
		CFG_FIXED_PATTERN = 2'd1,
		CFG_REGION_BASE   = 2'd2
	} cfg_idx_t;

	localparam int unsigned IDX_W = 24;
	localparam logic [31:0] REGION_WORDS = 32'd16777216;
	localparam logic [31:0] BASE_RESET = 32'h0010_0000;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		mode_t       test_mode;
		logic [31:0] fixed_pattern;
		logic [31:0] region_base;
	} cfg_t;

	typedef struct packed {
		cmd_t             command;
		logic [IDX_W-1:0] word_index;
		logic [4:0]       bit_position;
		logic             invert_walk;
		logic [31:0]      read_data;
	} in_word_t;

	typedef struct packed {
		logic [31:0]      expected_word;
		logic             mismatch;
		logic [31:0]      error_count;
		logic             fail_seen;
		logic [IDX_W-1:0] first_fail_index;
		logic [31:0]      first_fail_address;
		logic [31:0]      first_expected;
		logic [31:0]      first_got;
	} out_word_t;

	function automatic logic [31:0] word_addr(logic [31:0] base, logic [IDX_W-1:0] idx);
		word_addr = base + {6'd0, idx, 2'b00};
	endfunction

endpackage

[rtl/mtpc_pattern.sv]
// Expected data word generator for the selected test mode.
module mtpc_pattern import mtpc_pkg::*; (
	input  cfg_t                   cfg,
	input  logic [IDX_W-1:0]       word_index,
	input  logic [4:0]             bit_position,
	input  logic                   invert_walk,
	output logic [31:0]            expected
);

	logic [31:0] walk;

	always_comb begin
		walk = 32'd1 << bit_position;
		case (cfg.test_mode)
			MODE_ADDR:  expected = word_addr(cfg.region_base, word_index);
			MODE_WALK:  expected = invert_walk ? ~walk : walk;
			MODE_FIXED: expected = cfg.fixed_pattern;
			MODE_INDEX: expected = {8'd0, word_index};
			default:    expected = {8'd0, word_index};
		endcase
	end

endmodule

[rtl/memory_test_pattern_checker_top.sv]
// Memory test pattern checker: pattern generation, readback compare and failure capture.
// One word is accepted per cycle, every cycle, as long as results are taken; each word
// gives exactly one result (the input register holds the word while the pattern select,
// 32-bit compare and saturating count form the result, which the result register
// captures once it is free to advance). A result held by a stall blocks the input only
// when the input register is also full. A clear word zeroes the statistics; a check
// word at or beyond the region size is not compared. Configuration writes are registered
// and must be made only while idle; the block itself does not enforce this.
`include "assert_macros.svh"
module memory_test_pattern_checker_top import mtpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_data
);

	cfg_t             cfg_q;
	logic             s1_valid;
	in_word_t         s1_word;
	logic             out_valid_s2;
	out_word_t        out_word_s2;

	logic [31:0]      total_q;
	logic             cap_valid_q;
	logic [IDX_W-1:0] cap_index_q;
	logic [31:0]      cap_expected_q;
	logic [31:0]      cap_read_q;

	logic [31:0]      total_d;
	logic             cap_valid_d;
	logic [IDX_W-1:0] cap_index_d;
	logic [31:0]      cap_expected_d;
	logic [31:0]      cap_read_d;

	logic [31:0]      expected;
	logic             miss;
	logic             adv2;
	logic             load2;

	assign adv2      = !out_valid_s2 || !out_stall;
	assign load2     = s1_valid && adv2;
	assign in_stall  = s1_valid && !adv2;
	assign out_valid = out_valid_s2;
	assign out_data  = out_word_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.test_mode     <= MODE_ADDR;
			cfg_q.fixed_pattern <= 32'd0;
			cfg_q.region_base   <= BASE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TEST_MODE:     cfg_q.test_mode <= mode_t'(cfg_data[1:0]);
				CFG_FIXED_PATTERN: cfg_q.fixed_pattern <= cfg_data;
				CFG_REGION_BASE:   cfg_q.region_base <= cfg_data;
				default:           ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (!in_stall) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			s1_word <= in_data;
		end
	end

	mtpc_pattern u_pattern (
		.cfg          (cfg_q),
		.word_index   (s1_word.word_index),
		.bit_position (s1_word.bit_position),
		.invert_walk  (s1_word.invert_walk),
		.expected     (expected)
	);

	always_comb begin
		total_d        = total_q;
		cap_valid_d    = cap_valid_q;
		cap_index_d    = cap_index_q;
		cap_expected_d = cap_expected_q;
		cap_read_d     = cap_read_q;
		miss           = 1'b0;
		if (s1_word.command == CMD_CLEAR) begin
			total_d        = 32'd0;
			cap_valid_d    = 1'b0;
			cap_index_d    = '0;
			cap_expected_d = 32'd0;
			cap_read_d     = 32'd0;
		end else if (s1_word.command == CMD_CHECK
				&& {8'd0, s1_word.word_index} < REGION_WORDS
				&& s1_word.read_data != expected) begin
			miss = 1'b1;
			if (!cap_valid_q) begin
				cap_valid_d    = 1'b1;
				cap_index_d    = s1_word.word_index;
				cap_expected_d = expected;
				cap_read_d     = s1_word.read_data;
			end
			if (total_q != COUNT_MAX) begin
				total_d = total_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q        <= 32'd0;
			cap_valid_q    <= 1'b0;
			cap_index_q    <= '0;
			cap_expected_q <= 32'd0;
			cap_read_q     <= 32'd0;
			out_valid_s2   <= 1'b0;
		end else begin
			if (adv2) begin
				out_valid_s2 <= s1_valid;
			end
			if (load2) begin
				total_q        <= total_d;
				cap_valid_q    <= cap_valid_d;
				cap_index_q    <= cap_index_d;
				cap_expected_q <= cap_expected_d;
				cap_read_q     <= cap_read_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load2) begin
			out_word_s2.expected_word      <= expected;
			out_word_s2.mismatch           <= miss;
			out_word_s2.error_count        <= total_d;
			out_word_s2.fail_seen          <= cap_valid_d;
			out_word_s2.first_fail_index   <= cap_index_d;
			out_word_s2.first_fail_address <= word_addr(cfg_q.region_base, cap_index_d);
			out_word_s2.first_expected     <= cap_expected_d;
			out_word_s2.first_got          <= cap_read_d;
		end
	end

	`ASSERT_CLK(a_count_monotonic, clk, arst_n, (load2 && s1_word.command != CMD_CLEAR) |=> (total_q >= $past(total_q)))
	`ASSERT_CLK(a_capture_has_count, clk, arst_n, cap_valid_q |-> (total_q != 32'd0))
	`ASSERT_CLK(a_stall_when_full, clk, arst_n, in_stall |-> (s1_valid && out_valid_s2 && out_stall))
	`ASSERT_CLK(a_miss_counted, clk, arst_n, (out_valid_s2 && out_word_s2.mismatch) |-> (out_word_s2.error_count != 32'd0 && out_word_s2.fail_seen))
	`ASSERT_CLK_ALWAYS(a_reset_idle, clk, !arst_n |=> (!out_valid_s2 && !s1_valid))

endmodule
